// ----- rtl/core/lztd_pkg.sv -----
// ============================================================================
// lztd_pkg
// Shared constants and controller/datapath interface types for the LZ
// texture decoder.
// ============================================================================
`default_nettype none

package lztd_pkg;

  // Default history window in bytes
  localparam int WINDOW_DEF = 4096;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int DIST_W    = 13;
  localparam int LEN_W     = 20;
  localparam int COUNT_W   = 5;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 32;

  // Number of copy modes with a distance register
  localparam int NUM_MODES = 7;

  // Saturation limit of the output length
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Control byte mode for literal runs and end marker
  localparam logic [MODE_W-1:0] MODE_LITERAL = 3'd0;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;     // take input word, restart on first byte
    logic set_lits;   // load literal run length from control byte
    logic set_end;    // mark stream ended (end marker)
    logic load_copy;  // load copy count and distance
    logic rd;         // read history for next copy byte
    logic emit_lit;   // emit latched byte as literal
    logic emit_copy;  // emit byte read from history
    logic emit_done;  // emit end-of-stream word
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ended;      // stream already finished
    logic lits_pend;  // literal bytes still expected
    logic mode_zero;  // latched control byte has mode 0
    logic count_zero; // latched control byte has count 0
    logic last;       // latched byte is the final one
    logic cnt_last;   // current copy byte is the final one
    logic out_free;   // output register can take a word
  } sts_t;

endpackage : lztd_pkg

`default_nettype wire

// ----- rtl/core/lz_texture_decoder.sv -----
// ============================================================================
// lz_texture_decoder
// Byte-serial LZ77-style decoder with per-mode back distances.
// ============================================================================
// One compressed byte is taken per word on the slave side. A control byte
// with mode 0 opens a literal run of its count (count 0 ends the stream);
// modes 1-7 copy count bytes from the output history at the distance held
// in register distances[N-1] (index N-1 on the cfg port). Each copied byte
// is first read from the single-port history ring (ST_READ), then written
// to it and loaded into the output register (ST_WRITE). The output
// register stalls the sequence while a word waits to be taken. The
// history needs no clearing after reset: reads beyond the bytes written
// since the stream start return 0.
// ============================================================================
`default_nettype none

module lz_texture_decoder #(
  parameter int WINDOW = lztd_pkg::WINDOW_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  // configuration write channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [lztd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [lztd_pkg::DIST_W-1:0]        cfg_data,
  // compressed input
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [lztd_pkg::TDATA_IN_W-1:0]    s_tdata,   // [7:0] in_byte
  input  wire                                s_tuser,   // [0] first_byte
  input  wire                                s_tlast,   // last_byte
  // decoded output
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [lztd_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [7:0] out_byte,
                                                        // [27:8] out_length, [31:28] 0
  output logic                               m_tuser,   // [0] done_res
  output logic                               m_tlast    // run_end
);

  lztd_pkg::cmd_t cmd;
  lztd_pkg::sts_t sts;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  lztd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lztd_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule : lz_texture_decoder

`default_nettype wire

// ----- rtl/core/lztd_ctrl.sv -----
// ============================================================================
// lztd_ctrl
// Sequencer for the LZ texture decoder: decodes each input word through
// the datapath, one result word at a time.
// ============================================================================
`default_nettype none

module lztd_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  lztd_pkg::sts_t      sts,
  output lztd_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.ended) begin
          state_next = ST_IDLE;
        end else if (sts.lits_pend) begin
          if (sts.out_free) begin
            cmd.emit_lit = 1'b1;
            state_next   = sts.last ? ST_DONE : ST_IDLE;
          end
        end else if (sts.mode_zero) begin
          if (sts.count_zero) begin
            cmd.set_end = 1'b1;
            state_next  = ST_DONE;
          end else begin
            cmd.set_lits = 1'b1;
            state_next   = sts.last ? ST_DONE : ST_IDLE;
          end
        end else if (sts.count_zero) begin
          state_next = sts.last ? ST_DONE : ST_IDLE;
        end else begin
          cmd.load_copy = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.emit_copy = 1'b1;
          if (sts.cnt_last) begin
            state_next = sts.last ? ST_DONE : ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : lztd_ctrl

`default_nettype wire

// ----- rtl/core/lztd_datapath.sv -----
// ============================================================================
// lztd_datapath
// Distance registers, stream counters, history ring and output register of
// the LZ texture decoder.
// ============================================================================
`default_nettype none

module lztd_datapath #(
  parameter int WINDOW = lztd_pkg::WINDOW_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // configuration
  input  wire                                   cfg_valid,
  input  wire  [lztd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [lztd_pkg::DIST_W-1:0]           cfg_data,
  // input word
  input  wire  [lztd_pkg::TDATA_IN_W-1:0]       s_tdata,
  input  wire                                   s_tuser,
  input  wire                                   s_tlast,
  // output word
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [lztd_pkg::TDATA_OUT_W-1:0]      m_tdata,
  output logic                                  m_tuser,
  output logic                                  m_tlast,
  // controller link
  input  lztd_pkg::cmd_t                        cmd,
  output lztd_pkg::sts_t                        sts
);

  localparam int AW = $clog2(WINDOW);
  localparam int FW = $clog2(WINDOW + 1);
  localparam int CW = (FW > lztd_pkg::DIST_W) ? FW : lztd_pkg::DIST_W;
  localparam logic [CW:0]   WIN_C  = (CW+1)'(WINDOW);
  localparam logic [AW-1:0] WR_TOP = AW'(WINDOW - 1);
  localparam logic [FW-1:0] FILL_TOP = FW'(WINDOW);
  localparam int PAD_W = lztd_pkg::TDATA_OUT_W - lztd_pkg::LEN_W - lztd_pkg::BYTE_W;

  // Control state
  logic [lztd_pkg::DIST_W-1:0]  distances [lztd_pkg::NUM_MODES];
  logic [lztd_pkg::COUNT_W-1:0] literals_left;
  logic [lztd_pkg::LEN_W-1:0]   produced;
  logic                         ended;
  logic [AW-1:0]                wr_pos;
  logic [FW-1:0]                filled;
  logic [lztd_pkg::COUNT_W-1:0] cnt;

  // Payload state
  logic [lztd_pkg::BYTE_W-1:0]  in_byte;
  logic                         last_q;
  logic [lztd_pkg::DIST_W-1:0]  copy_dist;
  logic [lztd_pkg::BYTE_W-1:0]  rdata;
  logic                         rd_ok;
  logic [lztd_pkg::BYTE_W-1:0]  out_byte;
  logic [lztd_pkg::LEN_W-1:0]   out_length;

  logic [lztd_pkg::BYTE_W-1:0]  history [WINDOW];

  logic [lztd_pkg::MODE_W-1:0]  mode;
  logic [lztd_pkg::COUNT_W-1:0] count;
  logic [CW:0]                  wr_ext;
  logic [CW:0]                  dist_ext;
  logic [CW:0]                  fill_ext;
  logic [CW:0]                  addr_wide;
  logic [AW-1:0]                rd_addr;
  logic                         dist_ok;
  logic                         emit;
  logic [lztd_pkg::BYTE_W-1:0]  emit_val;
  logic [lztd_pkg::LEN_W-1:0]   produced_next;

  // Split the control byte
  assign mode  = in_byte[lztd_pkg::MODE_W-1:0];
  assign count = in_byte[lztd_pkg::BYTE_W-1:lztd_pkg::MODE_W];

  // Back address into the ring, wrapping below zero
  assign wr_ext    = (CW+1)'(wr_pos);
  assign dist_ext  = (CW+1)'(copy_dist);
  assign fill_ext  = (CW+1)'(filled);
  assign addr_wide = (wr_ext >= dist_ext) ? (wr_ext - dist_ext)
                                          : (wr_ext + WIN_C - dist_ext);
  assign rd_addr   = addr_wide[AW-1:0];
  assign dist_ok   = (copy_dist != '0) && (dist_ext <= fill_ext);

  // Byte to emit and saturated count
  assign emit          = cmd.emit_lit | cmd.emit_copy;
  assign emit_val      = cmd.emit_lit ? in_byte : (rd_ok ? rdata : '0);
  assign produced_next = (produced < lztd_pkg::LEN_MAX) ? (produced + 1'b1) : produced;

  // Status to controller
  always_comb begin
    sts            = '0;
    sts.ended      = ended;
    sts.lits_pend  = (literals_left != '0);
    sts.mode_zero  = (mode == lztd_pkg::MODE_LITERAL);
    sts.count_zero = (count == '0);
    sts.last       = last_q;
    sts.cnt_last   = (cnt == lztd_pkg::COUNT_W'(1));
    sts.out_free   = !m_tvalid || m_tready;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lztd_pkg::NUM_MODES; i++) begin
        distances[i] <= lztd_pkg::DIST_W'(1);
      end
      literals_left <= '0;
      produced      <= '0;
      ended         <= 1'b0;
      wr_pos        <= '0;
      filled        <= '0;
      cnt           <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // register writes; index seven is ignored
      if (cfg_valid && (cfg_index < lztd_pkg::CFG_IDX_W'(lztd_pkg::NUM_MODES))) begin
        distances[cfg_index] <= cfg_data;
      end
      // restart counts on the first byte of a stream
      if (cmd.accept && s_tuser) begin
        literals_left <= '0;
        produced      <= '0;
        ended         <= 1'b0;
        wr_pos        <= '0;
        filled        <= '0;
      end
      if (cmd.set_lits) begin
        literals_left <= count;
      end
      if (cmd.set_end) begin
        ended <= 1'b1;
      end
      if (cmd.load_copy) begin
        cnt <= count;
      end
      // advance ring and length on every decoded byte
      if (emit) begin
        wr_pos   <= (wr_pos == WR_TOP) ? '0 : (wr_pos + 1'b1);
        filled   <= (filled == FILL_TOP) ? filled : (filled + 1'b1);
        produced <= produced_next;
      end
      if (cmd.emit_lit) begin
        literals_left <= literals_left - 1'b1;
      end
      if (cmd.emit_copy) begin
        cnt <= cnt - 1'b1;
      end
      if (cmd.emit_done) begin
        ended         <= 1'b1;
        literals_left <= '0;
      end
      // hold output word until taken
      if (emit || cmd.emit_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_byte <= s_tdata[lztd_pkg::BYTE_W-1:0];
      last_q  <= s_tlast;
    end
    if (cmd.load_copy) begin
      copy_dist <= distances[mode - 1'b1];
    end
    if (cmd.rd) begin
      rd_ok <= dist_ok;
    end
    if (emit) begin
      out_byte   <= emit_val;
      out_length <= produced_next;
      m_tuser    <= 1'b0;
      m_tlast    <= cmd.emit_lit ? !last_q : (sts.cnt_last && !last_q);
    end else if (cmd.emit_done) begin
      out_byte   <= '0;
      out_length <= produced;
      m_tuser    <= 1'b1;
      m_tlast    <= 1'b1;
    end
  end

  // History ring: write on emit, registered read
  always_ff @(posedge clk) begin
    if (emit) begin
      history[wr_pos] <= emit_val;
    end
    if (cmd.rd) begin
      rdata <= history[rd_addr];
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_length, out_byte};

endmodule : lztd_datapath

`default_nettype wire
